[sv/ccfr_pkg.sv]
// Shared constants and the CRC byte step for the CRC-checked frame receiver.
// No dependencies; used by crc_checked_frame_receiver_core.
package ccfr_pkg;

	localparam int BYTE_W = 8;
	localparam int CRC_W  = 16;
	localparam int CFG_W  = 16;
	localparam int LREG_W = 7;
	localparam int IDX_W  = 6;

	localparam logic [BYTE_W-1:0] START_TELEMETRY = 8'hFA;
	localparam logic [BYTE_W-1:0] START_LOGGING   = 8'hFB;

	typedef enum logic [1:0] {
		CFG_POLY    = 2'd0,
		CFG_TEL_LEN = 2'd1,
		CFG_LOG_LEN = 2'd2
	} cfg_idx_t;

	// One byte through the MSB-first CRC: xor into the top byte, then eight
	// conditional polynomial folds, each followed by a left shift.
	function automatic logic [CRC_W-1:0] crc_byte(
		input logic [CRC_W-1:0]  crc_in,
		input logic [BYTE_W-1:0] data,
		input logic [CRC_W-1:0]  poly
	);
		logic [CRC_W-1:0] c;
		c = crc_in ^ {data, {(CRC_W-BYTE_W){1'b0}}};
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[CRC_W-1]) begin
				c = c ^ poly;
			end
			c = {c[CRC_W-2:0], 1'b0};
		end
		return c;
	endfunction

endpackage

[sv/crc_checked_frame_receiver_core.sv]
// CRC-checked frame receiver: start-byte framing, payload store, CRC-16 check
// and payload replay. Depends on ccfr_pkg.
//
//  channel  | signals                         | direction | width
//  ---------+---------------------------------+-----------+-------------------
//  input    | in_valid, in_stall, rx_byte     | in        | 8
//  output   | out_valid, out_stall,           | out       | 8, 6, 1, 1, 1
//           |  payload_byte, byte_index,      |           |
//           |  frame_kind, crc_ok, last       |           |
//  config   | cfg_we, cfg_index, cfg_data     | in        | 2, 16
//
// Start, payload and CRC low beats are taken one per cycle. After the CRC high
// beat the input stalls while one shared CRC byte unit walks the payload store
// (one byte per cycle), then each verified byte is replayed through the store's
// registered read port, or one failure beat is sent instead. Output beats wait
// in one output register; a stall there holds replay and the failure beat.
// Reset is asynchronous; the payload store itself is not cleared.
module crc_checked_frame_receiver_core #(
	parameter int MAX_PAYLOAD = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ccfr_pkg::BYTE_W-1:0]   rx_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ccfr_pkg::BYTE_W-1:0]   payload_byte,
	output logic [ccfr_pkg::IDX_W-1:0]    byte_index,
	output logic                          frame_kind,
	output logic                          crc_ok,
	output logic                          last,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [ccfr_pkg::CFG_W-1:0]    cfg_data
);

	localparam int ADDR_W = $clog2(MAX_PAYLOAD);
	localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAYLOAD,
		ST_CRC_HI,
		ST_CALC,
		ST_EMIT,
		ST_FAIL
	} state_t;

	state_t state_q;

	logic [ccfr_pkg::CRC_W-1:0]  poly_q;
	logic [ccfr_pkg::LREG_W-1:0] tel_len_q;
	logic [ccfr_pkg::LREG_W-1:0] log_len_q;

	logic [LEN_W-1:0]            len_q;
	logic [LEN_W-1:0]            byte_cnt_q;
	logic                        kind_q;
	logic [ccfr_pkg::BYTE_W-1:0] crc_lo_q;
	logic [ccfr_pkg::CRC_W-1:0]  rx_crc_q;
	logic [ccfr_pkg::CRC_W-1:0]  crc_q;
	logic [LEN_W-1:0]            rd_cnt_q;

	logic                        pend_s1;
	logic [ADDR_W-1:0]           idx_s1;
	logic [ccfr_pkg::BYTE_W-1:0] rd_data_s1;

	logic                        out_valid_q;
	logic [ccfr_pkg::BYTE_W-1:0] out_byte_q;
	logic [ccfr_pkg::IDX_W-1:0]  out_idx_q;
	logic                        out_kind_q;
	logic                        out_ok_q;
	logic                        out_last_q;

	logic [ccfr_pkg::BYTE_W-1:0] mem [MAX_PAYLOAD];

	logic                        in_fire;
	logic                        out_free;
	logic                        out_load;
	logic                        rd_more;
	logic                        issue;
	logic                        wr_en;
	logic [LEN_W-1:0]            start_len;
	logic                        start_hit;
	logic                        start_kind;

	assign in_stall = !(state_q == ST_IDLE || state_q == ST_PAYLOAD || state_q == ST_CRC_HI);
	assign in_fire  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == ST_EMIT && pend_s1) || (state_q == ST_FAIL && out_free);
	assign rd_more  = rd_cnt_q < len_q;
	assign wr_en    = in_fire && state_q == ST_PAYLOAD && byte_cnt_q < len_q;

	always_comb begin
		issue = 1'b0;
		unique case (state_q)
			ST_CALC: issue = rd_more;
			ST_EMIT: issue = rd_more && !pend_s1 && out_free;
			default: issue = 1'b0;
		endcase
	end

	// Length sampled at the start beat, clamped to 1..MAX_PAYLOAD.
	always_comb begin
		int raw;
		start_hit  = rx_byte == ccfr_pkg::START_TELEMETRY || rx_byte == ccfr_pkg::START_LOGGING;
		start_kind = rx_byte == ccfr_pkg::START_LOGGING;
		raw = start_kind ? int'(log_len_q) : int'(tel_len_q);
		if (raw < 1) begin
			raw = 1;
		end else if (raw > MAX_PAYLOAD) begin
			raw = MAX_PAYLOAD;
		end
		start_len = LEN_W'(raw);
	end

	// Payload store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[byte_cnt_q[ADDR_W-1:0]] <= rx_byte;
		end
		rd_data_s1 <= mem[rd_cnt_q[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			poly_q      <= 16'h1021;
			tel_len_q   <= 7'd40;
			log_len_q   <= 7'd51;
			len_q       <= '0;
			byte_cnt_q  <= '0;
			kind_q      <= 1'b0;
			crc_lo_q    <= '0;
			rx_crc_q    <= '0;
			crc_q       <= '0;
			rd_cnt_q    <= '0;
			pend_s1     <= 1'b0;
			idx_s1      <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_idx_q   <= '0;
			out_kind_q  <= 1'b0;
			out_ok_q    <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					ccfr_pkg::CFG_POLY:    poly_q    <= cfg_data;
					ccfr_pkg::CFG_TEL_LEN: tel_len_q <= cfg_data[ccfr_pkg::LREG_W-1:0];
					ccfr_pkg::CFG_LOG_LEN: log_len_q <= cfg_data[ccfr_pkg::LREG_W-1:0];
					default: ;
				endcase
			end

			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end

			pend_s1 <= issue;
			idx_s1  <= rd_cnt_q[ADDR_W-1:0];
			if (issue) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && start_hit) begin
						kind_q     <= start_kind;
						len_q      <= start_len;
						byte_cnt_q <= '0;
						state_q    <= ST_PAYLOAD;
					end
				end
				ST_PAYLOAD: begin
					if (in_fire) begin
						if (byte_cnt_q >= len_q) begin
							crc_lo_q   <= rx_byte;
							byte_cnt_q <= '0;
							state_q    <= ST_CRC_HI;
						end else begin
							byte_cnt_q <= byte_cnt_q + 1'b1;
						end
					end
				end
				ST_CRC_HI: begin
					if (in_fire) begin
						rx_crc_q <= {rx_byte, crc_lo_q};
						crc_q    <= '0;
						rd_cnt_q <= '0;
						state_q  <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (pend_s1) begin
						crc_q <= ccfr_pkg::crc_byte(crc_q, rd_data_s1, poly_q);
					end else if (!rd_more) begin
						rd_cnt_q <= '0;
						state_q  <= (crc_q == rx_crc_q) ? ST_EMIT : ST_FAIL;
					end
				end
				ST_EMIT: begin
					// issue only when the output register is free, so it is
					// empty by the time the read data lands
					if (pend_s1) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= rd_data_s1;
						out_idx_q   <= idx_s1[ccfr_pkg::IDX_W-1:0];
						out_kind_q  <= kind_q;
						out_ok_q    <= 1'b1;
						out_last_q  <= (LEN_W'(idx_s1) + 1'b1) == len_q;
					end else if (!rd_more) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FAIL: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= '0;
						out_idx_q   <= '0;
						out_kind_q  <= kind_q;
						out_ok_q    <= 1'b0;
						out_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign payload_byte = out_byte_q;
	assign byte_index   = out_idx_q;
	assign frame_kind   = out_kind_q;
	assign crc_ok       = out_ok_q;
	assign last         = out_last_q;

endmodule

[bench/crc_checked_frame_receiver_core_tb.sv]
// Self-checking bench for crc_checked_frame_receiver_core: framed byte stream in,
// verified payload beats or CRC failure beats out, checked against a local model.
// Depends on ccfr_pkg and the core RTL only.
module crc_checked_frame_receiver_core_tb;

	localparam int MAXP           = 64;
	localparam int ITEMS          = 370;
	localparam int DRAIN_CYC      = 220;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef enum logic [1:0] {
		RX_IDLE,
		RX_BODY,
		RX_CRC_HI
	} rx_phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic [5:0] idx;
		logic       kind;
		logic       ok;
		logic       last;
	} beat_t;

	typedef logic [7:0] byte_q_t [$];

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic [ccfr_pkg::BYTE_W-1:0]   rx_byte;
	logic                          out_valid;
	logic                          out_stall;
	logic [ccfr_pkg::BYTE_W-1:0]   payload_byte;
	logic [ccfr_pkg::IDX_W-1:0]    byte_index;
	logic                          frame_kind;
	logic                          crc_ok;
	logic                          last;
	logic                          cfg_we;
	logic [1:0]                    cfg_index;
	logic [ccfr_pkg::CFG_W-1:0]    cfg_data;

	// local copy of the receiver: registers and frame state
	logic [15:0] poly_r;
	logic [6:0]  tel_len_r;
	logic [6:0]  log_len_r;
	rx_phase_t   rx_phase;
	int          frame_len;
	int          got_cnt;
	logic        kind_r;
	logic [7:0]  crc_lo_r;
	logic [7:0]  frame_buf [MAXP];

	beat_t replay_q [$];
	beat_t want;
	int    n_errors = 0;
	int    n_items;
	int    quiet_cycles = 0;
	bit    in_quiet;
	bit    out_quiet;

	crc_checked_frame_receiver_core #(
		.MAX_PAYLOAD(MAXP)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.payload_byte(payload_byte),
		.byte_index(byte_index),
		.frame_kind(frame_kind),
		.crc_ok(crc_ok),
		.last(last),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] d,
			input logic [15:0] poly);
		logic [15:0] r;
		r = crc ^ {d, 8'h00};
		repeat (8) begin
			r = r[15] ? ((r ^ poly) << 1) : (r << 1);
		end
		return r;
	endfunction

	function automatic int clamp_len(input logic [6:0] l);
		if (l == 7'd0) return 1;
		if (l > 7'(MAXP)) return MAXP;
		return int'(l);
	endfunction

	function automatic byte_q_t rand_body(input int n);
		byte_q_t q;
		q = {};
		repeat (n) q.push_back(8'($urandom_range(0, 255)));
		return q;
	endfunction

	// advance the local receiver by one accepted byte, queue the beats it releases
	function automatic void absorb_rx_byte(input logic [7:0] b);
		logic [15:0] crc;
		beat_t       bt;
		int          i;
		case (rx_phase)
			RX_BODY: begin
				if (got_cnt >= frame_len) begin
					crc_lo_r = b;
					got_cnt  = 0;
					rx_phase = RX_CRC_HI;
				end else begin
					frame_buf[got_cnt] = b;
					got_cnt++;
				end
			end
			RX_CRC_HI: begin
				rx_phase = RX_IDLE;
				crc = 16'h0000;
				for (i = 0; i < frame_len; i++) crc = crc_fold(crc, frame_buf[i], poly_r);
				if (crc == {b, crc_lo_r}) begin
					for (i = 0; i < frame_len; i++) begin
						bt.data = frame_buf[i];
						bt.idx  = 6'(i);
						bt.kind = kind_r;
						bt.ok   = 1'b1;
						bt.last = (i == frame_len - 1);
						replay_q.push_back(bt);
					end
				end else begin
					bt      = '0;
					bt.kind = kind_r;
					bt.last = 1'b1;
					replay_q.push_back(bt);
				end
			end
			default: begin
				if (b == ccfr_pkg::START_TELEMETRY || b == ccfr_pkg::START_LOGGING) begin
					kind_r    = (b == ccfr_pkg::START_LOGGING);
					frame_len = clamp_len(kind_r ? log_len_r : tel_len_r);
					got_cnt   = 0;
					rx_phase  = RX_BODY;
				end
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			n_errors++;
		end
	endfunction

	// all driving tasks start and end at a falling edge
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = in_quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		rx_byte  = b;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		// bytes dropped while idle don't count
		if (!(rx_phase == RX_IDLE && b != ccfr_pkg::START_TELEMETRY &&
				b != ccfr_pkg::START_LOGGING)) n_items++;
		absorb_rx_byte(b);
	endtask

	task automatic settle();
		in_valid = 1'b0;
		while (replay_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYC) @(negedge clk);
	endtask

	task automatic write_reg(input ccfr_pkg::cfg_idx_t idx, input logic [15:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			ccfr_pkg::CFG_POLY:    poly_r    = val;
			ccfr_pkg::CFG_TEL_LEN: tel_len_r = val[6:0];
			ccfr_pkg::CFG_LOG_LEN: log_len_r = val[6:0];
			default: ;
		endcase
	endtask

	// optional hold: after hold_at payload bytes, drain and write one register mid-frame
	task automatic send_frame(input logic logging, input byte_q_t body, input int corrupt,
			input int hold_at, input ccfr_pkg::cfg_idx_t hold_reg,
			input logic [15:0] hold_val);
		logic [15:0] crc;
		int          i;
		send_byte(logging ? ccfr_pkg::START_LOGGING : ccfr_pkg::START_TELEMETRY);
		for (i = 0; i <= body.size(); i++) begin
			if (i == hold_at) begin
				settle();
				write_reg(hold_reg, hold_val);
			end
			if (i < body.size()) send_byte(body[i]);
		end
		crc = 16'h0000;
		foreach (body[j]) crc = crc_fold(crc, body[j], poly_r);
		if (corrupt == 1) crc[7:0] ^= 8'($urandom_range(1, 255));
		if (corrupt == 2) crc[15:8] ^= 8'($urandom_range(1, 255));
		send_byte(crc[7:0]);
		send_byte(crc[15:8]);
	endtask

	task automatic send_random_frame(input logic logging, input int corrupt);
		send_frame(logging, rand_body(clamp_len(logging ? log_len_r : tel_len_r)), corrupt,
			-1, ccfr_pkg::CFG_POLY, 16'h0000);
	endtask

	task automatic test_reset_defaults();
		send_random_frame(1'b0, 0);
		send_random_frame(1'b1, 0);
	endtask

	task automatic test_start_bytes();
		byte_q_t body;
		settle();
		write_reg(ccfr_pkg::CFG_POLY, 16'h1021);
		write_reg(ccfr_pkg::CFG_TEL_LEN, 16'd1);
		write_reg(ccfr_pkg::CFG_LOG_LEN, 16'd2);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hF9);
		send_byte(8'hFC);
		body = {ccfr_pkg::START_TELEMETRY};
		send_frame(1'b0, body, 0, -1, ccfr_pkg::CFG_POLY, 16'h0000);
		body = {ccfr_pkg::START_LOGGING, 8'h00};
		send_frame(1'b1, body, 0, -1, ccfr_pkg::CFG_POLY, 16'h0000);
		body = {8'hFF};
		send_frame(1'b0, body, 0, -1, ccfr_pkg::CFG_POLY, 16'h0000);
	endtask

	task automatic test_crc_mismatch();
		byte_q_t body;
		body = {8'hA5};
		send_frame(1'b0, body, 1, -1, ccfr_pkg::CFG_POLY, 16'h0000);
		body = {8'h5A, 8'hC3};
		send_frame(1'b1, body, 2, -1, ccfr_pkg::CFG_POLY, 16'h0000);
	endtask

	task automatic test_poly_extremes();
		byte_q_t body;
		settle();
		write_reg(ccfr_pkg::CFG_POLY, 16'hFFFF);
		body = {8'h80};
		send_frame(1'b0, body, 0, -1, ccfr_pkg::CFG_POLY, 16'h0000);
		settle();
		write_reg(ccfr_pkg::CFG_POLY, 16'h0000);
		body = {8'h01, 8'hFE};
		send_frame(1'b1, body, 0, -1, ccfr_pkg::CFG_POLY, 16'h0000);
	endtask

	task automatic test_length_clamp();
		byte_q_t body;
		settle();
		write_reg(ccfr_pkg::CFG_POLY, 16'h1021);
		write_reg(ccfr_pkg::CFG_TEL_LEN, 16'd0);
		write_reg(ccfr_pkg::CFG_LOG_LEN, 16'h007F);
		body = {8'h3C};
		send_frame(1'b0, body, 0, -1, ccfr_pkg::CFG_POLY, 16'h0000);
		send_random_frame(1'b1, 0);
	endtask

	// length is latched at the start byte
	task automatic test_length_latch();
		settle();
		write_reg(ccfr_pkg::CFG_TEL_LEN, 16'd3);
		send_frame(1'b0, rand_body(3), 0, 1, ccfr_pkg::CFG_TEL_LEN, 16'd5);
		send_random_frame(1'b0, 0);
	endtask

	// polynomial is taken when the CRC high byte lands
	task automatic test_poly_timing();
		settle();
		write_reg(ccfr_pkg::CFG_POLY, 16'h1021);
		write_reg(ccfr_pkg::CFG_LOG_LEN, 16'd4);
		send_frame(1'b1, rand_body(4), 0, 2, ccfr_pkg::CFG_POLY, 16'h8005);
	endtask

	function automatic logic [15:0] pick_len();
		if ($urandom_range(0, 11) == 0) return 16'($urandom_range(65, 127));
		return 16'($urandom_range(0, 8));
	endfunction

	task automatic test_random_frames();
		int         phase_end;
		int         k;
		logic       logging;
		logic [7:0] b;
		while (n_items < ITEMS) begin
			settle();
			in_quiet  = ($urandom_range(0, 3) == 0);
			out_quiet = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 4))
				0: write_reg(ccfr_pkg::CFG_POLY, 16'h0000);
				1: write_reg(ccfr_pkg::CFG_POLY, 16'hFFFF);
				2: write_reg(ccfr_pkg::CFG_POLY, 16'h1021);
				default: write_reg(ccfr_pkg::CFG_POLY, 16'($urandom_range(0, 65535)));
			endcase
			write_reg(ccfr_pkg::CFG_TEL_LEN, pick_len());
			write_reg(ccfr_pkg::CFG_LOG_LEN, pick_len());
			phase_end = n_items + 50;
			while (n_items < phase_end && n_items < ITEMS) begin
				// realign after a broken frame
				while (rx_phase != RX_IDLE) send_byte(8'($urandom_range(0, 255)));
				logging = 1'($urandom_range(0, 1));
				case ($urandom_range(0, 15))
					0: begin
						repeat ($urandom_range(1, 3)) begin
							do b = 8'($urandom_range(0, 255));
							while (b == ccfr_pkg::START_TELEMETRY ||
								b == ccfr_pkg::START_LOGGING);
							send_byte(b);
						end
					end
					1: send_random_frame(logging, 1);
					2: send_random_frame(logging, 2);
					3: begin
						send_byte(logging ? ccfr_pkg::START_LOGGING :
							ccfr_pkg::START_TELEMETRY);
						k = $urandom_range(0, frame_len);
						repeat (k) send_byte(8'($urandom_range(0, 255)));
					end
					default: send_random_frame(logging, 0);
				endcase
			end
		end
		in_quiet  = 1'b0;
		out_quiet = 1'b0;
	endtask

	// output side: random stall before each beat
	initial begin
		int hold;
		out_stall = 1'b0;
		forever begin
			hold = out_quiet ? 0 : $urandom_range(0, 14);
			if (hold > 0) begin
				out_stall = 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (replay_q.size() == 0) begin
				$error("beat with none pending: payload_byte %0d byte_index %0d crc_ok %0d",
					payload_byte, byte_index, crc_ok);
				n_errors++;
			end else begin
				want = replay_q.pop_front();
				check_field("payload_byte", want.data, payload_byte);
				check_field("byte_index", want.idx, byte_index);
				check_field("frame_kind", want.kind, frame_kind);
				check_field("crc_ok", want.ok, crc_ok);
				check_field("last", want.last, last);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("[crc_checked_frame_receiver_core] ERROR");
					$finish;
				end
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		rx_byte      = 8'h00;
		cfg_we       = 1'b0;
		cfg_index    = ccfr_pkg::CFG_POLY;
		cfg_data     = '0;
		poly_r       = 16'h1021;
		tel_len_r    = 7'd40;
		log_len_r    = 7'd51;
		rx_phase     = RX_IDLE;
		frame_len    = 0;
		got_cnt      = 0;
		kind_r       = 1'b0;
		crc_lo_r     = 8'h00;
		n_items      = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_start_bytes();
		test_crc_mismatch();
		test_poly_extremes();
		test_length_clamp();
		test_length_latch();
		test_poly_timing();
		test_random_frames();

		settle();
		if (n_errors == 0) begin
			$display("[crc_checked_frame_receiver_core] OK");
		end else begin
			$display("[crc_checked_frame_receiver_core] ERROR");
		end
		$finish;
	end

endmodule
